// ----- rtl/crfc_pkg.sv -----
// shared constants, types and the decimal digit step of the frame checker
package crfc_pkg;

  // frame delimiters
  localparam logic [7:0] END_MARK = 8'd35;
  localparam logic [7:0] SEP_MARK = 8'd44;
  localparam logic [7:0] DIGIT_0  = 8'd48;
  localparam logic [7:0] DIGIT_9  = 8'd57;

  // value limits
  localparam logic [15:0] VALUE_MAX       = 16'hFFFF;
  localparam int          MAX_CONTENT_DEF = 1023;

  // configuration
  localparam int          PADDR_W           = 3;
  localparam logic        REG_LOCAL_ADDRESS = 1'b0;
  localparam logic [15:0] LOCAL_ADDRESS_RST = 16'd1;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_LENGTH = 2'd1;
  localparam logic [1:0] VERDICT_OTHER  = 2'd2;

  typedef struct packed {
    logic        done;
    logic [15:0] acc;
  } digit_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] recipient;
    logic [15:0] declared_length;
    logic [9:0]  content_length;
    logic [15:0] publish_sequence;
    logic [15:0] length_error_total;
  } result_t;

  // one step of decimal reading, saturating at the value maximum
  function automatic digit_t take_digit(input logic [7:0] b, input digit_t cur);
    logic [19:0] v;
    digit_t      r;
    r = cur;
    v = '0;
    if (!cur.done) begin
      if (b inside {[DIGIT_0:DIGIT_9]}) begin
        v = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + 20'(b - DIGIT_0);
        r.acc = (v > 20'(VALUE_MAX)) ? VALUE_MAX : v[15:0];
      end else begin
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/csv_radio_frame_checker.sv -----
// A '#' byte gives its result through the byte register, then the result register;
// other bytes give no result.
// Throughput: one byte per cycle, set by the combinational parser step; a '#'
// waits in the byte register only while the result register is full and not taken.
// Reset (rst, synchronous): frame state and counters clear, local_address goes to 1.
module csv_radio_frame_checker #(
  parameter int MAX_CONTENT = crfc_pkg::MAX_CONTENT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crfc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   verdict,
  output logic [15:0]                  recipient,
  output logic [15:0]                  declared_length,
  output logic [9:0]                   content_length,
  output logic [15:0]                  publish_sequence,
  output logic [15:0]                  length_error_total
);

  logic              byte_valid;
  logic [7:0]        byte_q;
  logic              byte_is_end;
  logic              advance;
  logic              step;
  logic [15:0]       local_address;
  crfc_pkg::result_t result;

  crfc_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .local_address (local_address)
  );

  crfc_frame_parser #(
    .MAX_CONTENT (MAX_CONTENT)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .byte_in       (byte_q),
    .local_address (local_address),
    .result        (result)
  );

  // a byte moves on unless it ends a frame and the result slot is blocked
  assign byte_is_end = (byte_q == crfc_pkg::END_MARK);
  assign advance     = !byte_is_end || !out_valid || out_ready;
  assign step        = byte_valid && advance;
  assign in_ready    = !byte_valid || advance;

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (step) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && byte_is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && byte_is_end) begin
      verdict            <= result.verdict;
      recipient          <= result.recipient;
      declared_length    <= result.declared_length;
      content_length     <= result.content_length;
      publish_sequence   <= result.publish_sequence;
      length_error_total <= result.length_error_total;
    end
  end

`ifndef ASSERT_OFF
  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == crfc_pkg::VERDICT_ACCEPT ||
                   verdict == crfc_pkg::VERDICT_LENGTH ||
                   verdict == crfc_pkg::VERDICT_OTHER))
    else $error("undefined verdict code");

  // an accepted frame has matching length and our address
  a_accept_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == crfc_pkg::VERDICT_ACCEPT) |->
      (recipient == local_address && declared_length[9:0] == content_length))
    else $error("accepted frame fails its own checks");

  // a frame end loaded into a full, stalled result slot would lose a result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(step && byte_is_end))
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- rtl/crfc_apb_regs.sv -----
// configuration register file on the apb port
module crfc_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crfc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [15:0]                  local_address
);

  logic wr_en;
  logic sel_local;

  // register index sits above the byte offset
  assign sel_local = (paddr[crfc_pkg::PADDR_W-1] == crfc_pkg::REG_LOCAL_ADDRESS);
  assign wr_en     = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // local address register
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= crfc_pkg::LOCAL_ADDRESS_RST;
    end else if (wr_en && sel_local) begin
      local_address <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (sel_local) begin
      prdata = {16'd0, local_address};
    end
  end

endmodule

// ----- rtl/crfc_frame_parser.sv -----
// per-frame field parsing, length and address check, and running counters
module crfc_frame_parser #(
  parameter int MAX_CONTENT = crfc_pkg::MAX_CONTENT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic [15:0]       local_address,
  output crfc_pkg::result_t result
);

  localparam int              CW      = $clog2(MAX_CONTENT + 1);
  localparam logic [CW-1:0]   CNT_MAX = CW'(MAX_CONTENT);

  logic [2:0]      comma_seen, comma_seen_next;
  crfc_pkg::digit_t recipient, recipient_next;
  crfc_pkg::digit_t length, length_next;
  logic [CW-1:0]   content_count, content_count_next;
  logic [15:0]     sequence_count, sequence_count_next;
  logic [15:0]     error_count, error_count_next;
  logic            is_end;
  logic            len_ok;
  logic [1:0]      verdict;

  assign is_end = (byte_in == crfc_pkg::END_MARK);
  assign len_ok = (length.acc == 16'(content_count));

  // next state and verdict for the byte in the processing stage
  always_comb begin
    comma_seen_next     = comma_seen;
    recipient_next      = recipient;
    length_next         = length;
    content_count_next  = content_count;
    sequence_count_next = sequence_count;
    error_count_next    = error_count;
    verdict             = crfc_pkg::VERDICT_ACCEPT;

    if (!is_end) begin
      if (comma_seen[2]) begin
        // content region, later commas included
        if (content_count < CNT_MAX) begin
          content_count_next = content_count + 1'b1;
        end
      end else if (byte_in == crfc_pkg::SEP_MARK) begin
        comma_seen_next = comma_seen + 3'd1;
      end else if (comma_seen == 3'd1) begin
        recipient_next = crfc_pkg::take_digit(byte_in, recipient);
      end else if (comma_seen == 3'd3) begin
        length_next = crfc_pkg::take_digit(byte_in, length);
      end
    end else begin
      // end of frame: check in order, then clear the frame
      if (!len_ok) begin
        verdict = crfc_pkg::VERDICT_LENGTH;
        if (error_count != crfc_pkg::VALUE_MAX) begin
          error_count_next = error_count + 16'd1;
        end
      end else if (recipient.acc != local_address) begin
        verdict = crfc_pkg::VERDICT_OTHER;
      end else begin
        sequence_count_next = sequence_count + 16'd1;
      end
      comma_seen_next    = '0;
      recipient_next     = '0;
      length_next        = '0;
      content_count_next = '0;
    end
  end

  // result fields as seen after this frame
  always_comb begin
    result.verdict            = verdict;
    result.recipient          = recipient.acc;
    result.declared_length    = length.acc;
    result.content_length     = 10'(content_count);
    result.publish_sequence   = sequence_count_next;
    result.length_error_total = error_count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comma_seen     <= '0;
      recipient      <= '0;
      length         <= '0;
      content_count  <= '0;
      sequence_count <= '0;
      error_count    <= '0;
    end else if (step) begin
      comma_seen     <= comma_seen_next;
      recipient      <= recipient_next;
      length         <= length_next;
      content_count  <= content_count_next;
      sequence_count <= sequence_count_next;
      error_count    <= error_count_next;
    end
  end

endmodule

// ----- tb/crfc_verdict_checker.sv -----
`timescale 1ns / 1ps
// frame verdict checker: follows the byte and register requests, predicts and compares results
module crfc_verdict_checker #(
  parameter int MAX_BODY = crfc_pkg::MAX_CONTENT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [crfc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [1:0]                   verdict,
  input  logic [15:0]                  recipient,
  input  logic [15:0]                  declared_length,
  input  logic [9:0]                   content_length,
  input  logic [15:0]                  publish_sequence,
  input  logic [15:0]                  length_error_total,
  output int                           mismatch_total,
  output int                           verdicts_pending
);

  localparam logic [crfc_pkg::PADDR_W-1:0] ADDR_LOCAL = {crfc_pkg::REG_LOCAL_ADDRESS, 2'b00};

  // predicted gateway state
  logic [15:0]       local_addr;
  logic [15:0]       rcpt_val;
  logic              rcpt_stop;
  logic [15:0]       dlen_val;
  logic              dlen_stop;
  logic [15:0]       accept_seq;
  logic [15:0]       len_err_total;
  int                frame_commas;
  int                body_count;
  int                mismatches = 0;
  crfc_pkg::result_t expected_verdicts[$];

  // one decimal character: {stopped, value}, saturating
  function automatic logic [16:0] read_decimal(input logic [7:0] b, input logic stop,
                                               input logic [15:0] val);
    int n;
    if (stop || b < crfc_pkg::DIGIT_0 || b > crfc_pkg::DIGIT_9) return {1'b1, val};
    n = int'(val) * 10 + int'(b - crfc_pkg::DIGIT_0);
    return {1'b0, (n > int'(crfc_pkg::VALUE_MAX)) ? crfc_pkg::VALUE_MAX : n[15:0]};
  endfunction

  task automatic clear_frame();
    frame_commas = 0;
    rcpt_val     = '0;
    rcpt_stop    = 1'b0;
    dlen_val     = '0;
    dlen_stop    = 1'b0;
    body_count   = 0;
  endtask

  // advance the parser by one byte; the end mark yields one expected verdict
  task automatic track_frame_byte(input logic [7:0] b);
    crfc_pkg::result_t r;
    if (b != crfc_pkg::END_MARK) begin
      if (frame_commas >= 4) begin
        if (body_count < MAX_BODY) body_count++;
      end else if (b == crfc_pkg::SEP_MARK) begin
        frame_commas++;
      end else if (frame_commas == 1) begin
        {rcpt_stop, rcpt_val} = read_decimal(b, rcpt_stop, rcpt_val);
      end else if (frame_commas == 3) begin
        {dlen_stop, dlen_val} = read_decimal(b, dlen_stop, dlen_val);
      end
    end else begin
      // length check first, then address, then accept
      if (int'(dlen_val) != body_count) begin
        r.verdict = crfc_pkg::VERDICT_LENGTH;
        if (len_err_total != crfc_pkg::VALUE_MAX) len_err_total++;
      end else if (rcpt_val != local_addr) begin
        r.verdict = crfc_pkg::VERDICT_OTHER;
      end else begin
        r.verdict = crfc_pkg::VERDICT_ACCEPT;
        accept_seq++;
      end
      r.recipient          = rcpt_val;
      r.declared_length    = dlen_val;
      r.content_length     = 10'(body_count);
      r.publish_sequence   = accept_seq;
      r.length_error_total = len_err_total;
      expected_verdicts.push_back(r);
      clear_frame();
    end
  endtask

  // compare one delivered verdict with the oldest prediction
  task automatic compare_verdict();
    crfc_pkg::result_t want;
    crfc_pkg::result_t got;
    got = {verdict, recipient, declared_length, content_length, publish_sequence,
           length_error_total};
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: verdict %0d delivered with none predicted", $realtime, verdict);
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.verdict !== want.verdict || got.recipient !== want.recipient ||
        got.declared_length !== want.declared_length ||
        got.content_length !== want.content_length ||
        got.publish_sequence !== want.publish_sequence ||
        got.length_error_total !== want.length_error_total) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: mismatch exp v=%0d rcpt=%0d dlen=%0d clen=%0d seq=%0d err=%0d",
                  " | got v=%0d rcpt=%0d dlen=%0d clen=%0d seq=%0d err=%0d"},
                 $realtime, want.verdict, want.recipient, want.declared_length,
                 want.content_length, want.publish_sequence, want.length_error_total,
                 got.verdict, got.recipient, got.declared_length,
                 got.content_length, got.publish_sequence, got.length_error_total);
    end
  endtask

  // sample requests at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      local_addr    = crfc_pkg::LOCAL_ADDRESS_RST;
      accept_seq    = '0;
      len_err_total = '0;
      expected_verdicts.delete();
    end else begin
      // unknown register addresses are ignored
      if (psel && penable && pwrite && pready && paddr == ADDR_LOCAL)
        local_addr = pwdata[15:0];
      if (in_valid && in_ready) track_frame_byte(rx_byte);
      if (out_valid && out_ready) compare_verdict();
    end
    verdicts_pending <= expected_verdicts.size();
    mismatch_total   <= mismatches;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, register writes, frame byte stimulus and final verdict
module testbench;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_BYTES = 130;
  localparam int N_PHASES    = 6;
  localparam logic [crfc_pkg::PADDR_W-1:0] ADDR_LOCAL = {crfc_pkg::REG_LOCAL_ADDRESS, 2'b00};
  localparam logic [crfc_pkg::PADDR_W-1:0] ADDR_SPARE = {~crfc_pkg::REG_LOCAL_ADDRESS, 2'b00};

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [crfc_pkg::PADDR_W-1:0] paddr     = '0;
  logic [31:0]                  pwdata    = '0;
  logic                         in_valid  = 1'b0;
  logic [7:0]                   rx_byte   = '0;
  logic                         out_ready = 1'b0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_ready;
  logic                         out_valid;
  logic [1:0]                   verdict;
  logic [15:0]                  recipient;
  logic [15:0]                  declared_length;
  logic [9:0]                   content_length;
  logic [15:0]                  publish_sequence;
  logic [15:0]                  length_error_total;
  int                           mismatch_total;
  int                           verdicts_pending;

  logic [15:0] cur_local = crfc_pkg::LOCAL_ADDRESS_RST;
  logic [7:0]  frame_bytes[$];
  int          send_calm   = 0;
  int          ready_calm  = 0;
  int          ready_stall = 0;
  int          ready_roll;
  int          idle_cycles = 0;
  int          phase_sent  = 0;

  always #10 clk = ~clk;

  csv_radio_frame_checker u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .verdict, .recipient, .declared_length, .content_length,
    .publish_sequence, .length_error_total
  );

  crfc_verdict_checker u_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_ready, .rx_byte, .out_valid, .out_ready,
    .verdict, .recipient, .declared_length, .content_length,
    .publish_sequence, .length_error_total,
    .mismatch_total, .verdicts_pending
  );

  // result side: calm stretches, short stalls and the odd long one
  always @(posedge clk) begin
    if (ready_calm > 0) begin
      ready_calm--;
      out_ready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall--;
      out_ready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 2) ready_calm = $urandom_range(50, 300);
      else if (ready_roll < 22) ready_stall = $urandom_range(1, 3);
      else if (ready_roll < 25) ready_stall = $urandom_range(10, 60);
      out_ready <= (ready_stall == 0);
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sender gap before the next byte
  function automatic int pick_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      send_calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  // hold off until every predicted verdict has been delivered
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [crfc_pkg::PADDR_W-1:0] addr,
                                input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_LOCAL) cur_local = data[15:0];
  endtask

  // any byte but the end mark, optionally no separators or digits
  function automatic logic [7:0] random_byte(input bit no_sep, input bit no_digit);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == crfc_pkg::END_MARK || (no_sep && b == crfc_pkg::SEP_MARK) ||
           (no_digit && b >= crfc_pkg::DIGIT_0 && b <= crfc_pkg::DIGIT_9));
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  // decimal field, sometimes with a leading zero or trailing junk that stops the reading
  task automatic push_field_value(input int n);
    if ($urandom_range(0, 9) == 0) push_text("0");
    push_text($sformatf("%0d", n));
    if ($urandom_range(0, 9) == 0) begin
      frame_bytes.push_back(random_byte(1'b1, 1'b1));
      push_text($sformatf("%0d", $urandom_range(0, 99)));
    end
  endtask

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 65535);
    return $urandom_range(65536, 9999999);
  endfunction

  // mostly well-formed frames, some truncated, some noise
  task automatic random_frame();
    int kind;
    int r;
    int stop_at;
    int body_len;
    int target;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 15)) frame_bytes.push_back(random_byte(1'b0, 1'b0));
    end else begin
      stop_at  = (kind < 16) ? $urandom_range(0, 3) : 4;
      body_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 12);
      target   = (stop_at == 4) ? body_len : 0;
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(random_byte(1'b1, 1'b0));
      if (stop_at >= 1) begin
        frame_bytes.push_back(crfc_pkg::SEP_MARK);
        r = $urandom_range(0, 99);
        if (r < 75) push_field_value(cur_local);
        else if (r < 95) push_field_value(pick_value());
      end
      if (stop_at >= 2) begin
        frame_bytes.push_back(crfc_pkg::SEP_MARK);
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(random_byte(1'b1, 1'b0));
      end
      if (stop_at >= 3) begin
        frame_bytes.push_back(crfc_pkg::SEP_MARK);
        r = $urandom_range(0, 99);
        if (r < 75) push_field_value(target);
        else if (r < 93) push_field_value(target + $urandom_range(1, 3));
        else if (r < 97) push_field_value(pick_value());
      end
      if (stop_at == 4) begin
        frame_bytes.push_back(crfc_pkg::SEP_MARK);
        repeat (body_len) frame_bytes.push_back(random_byte(1'b0, 1'b0));
      end
    end
    frame_bytes.push_back(crfc_pkg::END_MARK);
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty frame, digit stop with odd content bytes, saturated address,
    // length mismatch with fewer than four commas
    push_text("#");
    push_text(",1a2,,3,");
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(crfc_pkg::SEP_MARK);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(crfc_pkg::END_MARK);
    push_text(",99999,,0#");
    push_text(",1,,4#");
    send_frame();
    drain_verdicts();

    // write to an unmapped address, which must change nothing
    write_register(ADDR_SPARE, $urandom());

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: write_register(ADDR_LOCAL, 32'(crfc_pkg::VALUE_MAX));
        1: write_register(ADDR_LOCAL, 32'd0);
        2: write_register(ADDR_LOCAL, 32'(crfc_pkg::LOCAL_ADDRESS_RST));
        3: write_register(ADDR_LOCAL, $urandom_range(2, 99));
        default: write_register(ADDR_LOCAL, $urandom());
      endcase
      // one oversized frame: saturated address and content count both match
      if (ph == 0) begin
        push_text(",70000,,1023,");
        repeat (1030) frame_bytes.push_back(random_byte(1'b0, 1'b0));
        frame_bytes.push_back(crfc_pkg::END_MARK);
        send_frame();
      end
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        if ($urandom_range(0, 24) == 0) drain_verdicts();
        random_frame();
        send_frame();
      end
      drain_verdicts();
    end

    repeat (6) @(posedge clk);
    if (mismatch_total == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/crfc_pkg.sv
rtl/crfc_apb_regs.sv
rtl/crfc_frame_parser.sv
rtl/csv_radio_frame_checker.sv
tb/crfc_verdict_checker.sv
tb/testbench.sv
